// ===== rtl/urf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urf_pkg: shared types and constants of the unsigned radix formatter
// Conversion codes, segment codes, ASCII constants, the command and status
// structs between controller and datapath, and the digit character function.
// ----------------------------------------------------------------------------
package urf_pkg;

    // Conversion codes of the func field
    localparam logic [2:0] FUNC_BIN = 3'd0;
    localparam logic [2:0] FUNC_OCT = 3'd1;
    localparam logic [2:0] FUNC_DEC = 3'd2;
    localparam logic [2:0] FUNC_HEXL = 3'd3;
    localparam logic [2:0] FUNC_HEXU = 3'd4;

    // Truncation codes of the size_mode field
    localparam logic [1:0] SIZE_8 = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;
    localparam logic [1:0] SIZE_64 = 2'd3;

    // ASCII characters
    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_A_UPPER = 8'h41;
    localparam logic [7:0] CHAR_A_LOWER = 8'h61;
    localparam logic [7:0] CHAR_X_UPPER = 8'h58;
    localparam logic [7:0] CHAR_X_LOWER = 8'h78;

    // Digit slots of the left-aligned digit register
    localparam int DIG_W = 80;
    localparam int BIN_W = 64;
    localparam int BCD_DIGITS = 20;
    localparam logic [6:0] SLOTS_BIN = 7'd64;
    localparam logic [6:0] SLOTS_OCT = 7'd22;
    localparam logic [6:0] SLOTS_HEX = 7'd16;
    localparam logic [6:0] SLOTS_DEC = 7'd20;

    // Output segments, in emission order
    typedef logic [2:0] t_seg;
    localparam t_seg SEG_NONE = 3'd0;
    localparam t_seg SEG_LEAD = 3'd1;
    localparam t_seg SEG_PFX = 3'd2;
    localparam t_seg SEG_ZERO = 3'd3;
    localparam t_seg SEG_DIGS = 3'd4;
    localparam t_seg SEG_TRAIL = 3'd5;
    localparam t_seg SEG_MARK = 3'd6;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic norm_step;
        logic setup;
        logic pop;
        t_seg emit_seg;
    } t_cmd;

    typedef struct packed {
        logic marker;
        logic decimal;
        logic conv_done;
        logic norm_done;
        logic seg_empty;
    } t_status;

    function automatic logic [7:0] f_digit_char(input logic [3:0] digit, input logic upper);
        logic [7:0] base;
        base = upper ? CHAR_A_UPPER : CHAR_A_LOWER;
        if (digit < 4'd10) begin
            f_digit_char = CHAR_ZERO + {4'd0, digit};
        end else begin
            f_digit_char = base + {4'd0, digit} - 8'd10;
        end
    endfunction

endpackage

// ===== rtl/urf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urf_if: input and output channels of the unsigned radix formatter
// Valid/ready channels; a word moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface urf_in_if;
    logic               valid;
    logic               ready;
    logic [63:0]        value;
    logic [2:0]         func;
    logic [1:0]         size_mode;
    logic               alternate;
    logic               zero_pad;
    logic               left_adjust;
    logic signed [6:0]  precision;
    logic [6:0]         min_width;

    modport source (
        output valid, value, func, size_mode, alternate, zero_pad, left_adjust,
               precision, min_width,
        input  ready
    );
    modport sink (
        input  valid, value, func, size_mode, alternate, zero_pad, left_adjust,
               precision, min_width,
        output ready
    );
endinterface

interface urf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;
    logic       empty_res;

    modport source (
        output valid, out_char, last, empty_res,
        input  ready
    );
    modport sink (
        input  valid, out_char, last, empty_res,
        output ready
    );
endinterface

// ===== rtl/urf_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urf_datapath: digit conversion and segment counters
// Holds the spec, runs double-dabble for decimal, strips leading zero digits,
// sizes the output segments and forms the current output character.
// ----------------------------------------------------------------------------
module urf_datapath #(
    parameter int MAX_FIELD_WIDTH = 64,
    parameter int MAX_PRECISION = 60
) (
    input  logic                i_clk,
    input  urf_pkg::t_cmd       i_cmd,
    output urf_pkg::t_status    o_status,
    input  logic [63:0]         i_value,
    input  logic [2:0]          i_func,
    input  logic [1:0]          i_size_mode,
    input  logic                i_alternate,
    input  logic                i_zero_pad,
    input  logic                i_left_adjust,
    input  logic signed [6:0]   i_precision,
    input  logic [6:0]          i_min_width,
    output logic [7:0]          o_out_char,
    output logic                o_last,
    output logic                o_empty_res
);

    logic [urf_pkg::DIG_W-1:0]  r_dig;
    logic [urf_pkg::BIN_W-1:0]  r_bin;
    logic [6:0]                 r_iter;
    logic [6:0]                 r_slots;
    logic [6:0]                 r_prec;
    logic [6:0]                 r_width;
    logic [6:0]                 r_lead_cnt;
    logic [6:0]                 r_zero_cnt;
    logic [6:0]                 r_trail_cnt;
    logic [1:0]                 r_pfx_cnt;
    logic [2:0]                 r_kind;
    logic                       r_has_prec;
    logic                       r_alt;
    logic                       r_lead_zero;
    logic                       r_left;
    logic                       r_nonzero;
    logic                       r_upper;
    logic                       r_pfx_hex;
    logic                       r_marker;

    // Load-time decode
    logic [63:0]                value_t;
    logic [63:0]                bin_load;
    logic [6:0]                 iter_load;
    logic [2:0]                 kind;
    logic [6:0]                 prec_in;
    logic [6:0]                 prec_sat;
    logic [6:0]                 width_sat;

    always_comb begin
        unique case (i_size_mode)
            urf_pkg::SIZE_8: begin
                value_t = {56'd0, i_value[7:0]};
                bin_load = {i_value[7:0], 56'd0};
                iter_load = 7'd8;
            end
            urf_pkg::SIZE_16: begin
                value_t = {48'd0, i_value[15:0]};
                bin_load = {i_value[15:0], 48'd0};
                iter_load = 7'd16;
            end
            urf_pkg::SIZE_32: begin
                value_t = {32'd0, i_value[31:0]};
                bin_load = {i_value[31:0], 32'd0};
                iter_load = 7'd32;
            end
            default: begin
                value_t = i_value;
                bin_load = i_value;
                iter_load = 7'd64;
            end
        endcase
    end

    always_comb begin
        unique case (i_func)
            urf_pkg::FUNC_BIN, urf_pkg::FUNC_OCT, urf_pkg::FUNC_HEXL,
            urf_pkg::FUNC_HEXU: kind = i_func;
            default:            kind = urf_pkg::FUNC_DEC;
        endcase
    end

    assign prec_in = {1'b0, i_precision[5:0]};
    assign prec_sat = (prec_in > 7'(MAX_PRECISION)) ? 7'(MAX_PRECISION) : prec_in;
    assign width_sat = (i_min_width > 7'(MAX_FIELD_WIDTH)) ? 7'(MAX_FIELD_WIDTH)
                                                           : i_min_width;

    // Double-dabble adjust, one pass over independent BCD digits
    logic [urf_pkg::DIG_W-1:0] bcd_adj;

    always_comb begin
        for (int k = 0; k < urf_pkg::BCD_DIGITS; k++) begin
            bcd_adj[k*4 +: 4] = (r_dig[k*4 +: 4] >= 4'd5) ? r_dig[k*4 +: 4] + 4'd3
                                                          : r_dig[k*4 +: 4];
        end
    end

    // Top digit and one-digit shift of the left-aligned digit register
    logic [3:0]                top_digit;
    logic [urf_pkg::DIG_W-1:0] dig_shift;

    always_comb begin
        unique case (r_kind)
            urf_pkg::FUNC_BIN: begin
                top_digit = {3'd0, r_dig[79]};
                dig_shift = {r_dig[78:0], 1'b0};
            end
            urf_pkg::FUNC_OCT: begin
                top_digit = {1'b0, r_dig[79:77]};
                dig_shift = {r_dig[76:0], 3'd0};
            end
            default: begin
                top_digit = r_dig[79:76];
                dig_shift = {r_dig[75:0], 4'd0};
            end
        endcase
    end

    // Segment sizing
    logic       is_hex;
    logic       prec_gt;
    logic [6:0] zero_len;
    logic [1:0] pfx_len;
    logic [6:0] body_len;
    logic [7:0] total_len;
    logic [6:0] pad_len;

    assign is_hex = (r_kind == urf_pkg::FUNC_HEXL) || (r_kind == urf_pkg::FUNC_HEXU);
    assign prec_gt = r_has_prec && (r_prec > r_slots);
    assign zero_len = prec_gt ? r_prec - r_slots : 7'd0;
    assign body_len = prec_gt ? r_prec : r_slots;

    always_comb begin
        pfx_len = 2'd0;
        if (r_alt && r_nonzero) begin
            if (is_hex) begin
                pfx_len = 2'd2;
            end else if (r_kind == urf_pkg::FUNC_OCT && !prec_gt) begin
                pfx_len = 2'd1;
            end
        end
    end

    assign total_len = {1'b0, body_len} + {6'd0, pfx_len};
    assign pad_len = ({1'b0, r_width} > total_len) ? r_width - total_len[6:0] : 7'd0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= kind;
            r_upper <= (i_func == urf_pkg::FUNC_HEXU);
            r_has_prec <= !i_precision[6];
            r_prec <= prec_sat;
            r_width <= width_sat;
            r_alt <= i_alternate;
            r_lead_zero <= i_precision[6] && i_zero_pad;
            r_left <= i_left_adjust;
            r_nonzero <= (value_t != 64'd0);
            r_marker <= !i_precision[6] && (prec_sat == 7'd0) && (value_t == 64'd0);
            r_bin <= bin_load;
            r_iter <= iter_load;
            unique case (kind)
                urf_pkg::FUNC_BIN, urf_pkg::FUNC_HEXL, urf_pkg::FUNC_HEXU: begin
                    r_dig <= {value_t, 16'd0};
                    r_slots <= (kind == urf_pkg::FUNC_BIN) ? urf_pkg::SLOTS_BIN
                                                           : urf_pkg::SLOTS_HEX;
                end
                urf_pkg::FUNC_OCT: begin
                    r_dig <= {2'd0, value_t, 14'd0};
                    r_slots <= urf_pkg::SLOTS_OCT;
                end
                default: begin
                    r_dig <= '0;
                    r_slots <= urf_pkg::SLOTS_DEC;
                end
            endcase
        end
        if (i_cmd.conv_step) begin
            r_dig <= {bcd_adj[78:0], r_bin[63]};
            r_bin <= {r_bin[62:0], 1'b0};
            r_iter <= r_iter - 7'd1;
        end
        if (i_cmd.norm_step) begin
            r_dig <= dig_shift;
            r_slots <= r_slots - 7'd1;
        end
        if (i_cmd.setup) begin
            r_zero_cnt <= zero_len;
            r_pfx_cnt <= pfx_len;
            r_pfx_hex <= (pfx_len == 2'd2);
            r_lead_cnt <= r_left ? 7'd0 : pad_len;
            r_trail_cnt <= r_left ? pad_len : 7'd0;
        end
        if (i_cmd.pop) begin
            case (i_cmd.emit_seg)
                urf_pkg::SEG_LEAD:  r_lead_cnt <= r_lead_cnt - 7'd1;
                urf_pkg::SEG_PFX:   r_pfx_cnt <= r_pfx_cnt - 2'd1;
                urf_pkg::SEG_ZERO:  r_zero_cnt <= r_zero_cnt - 7'd1;
                urf_pkg::SEG_DIGS: begin
                    r_dig <= dig_shift;
                    r_slots <= r_slots - 7'd1;
                end
                urf_pkg::SEG_TRAIL: r_trail_cnt <= r_trail_cnt - 7'd1;
                default: ;
            endcase
        end
    end

    // Current output word and status
    always_comb begin
        o_out_char = urf_pkg::CHAR_NUL;
        o_last = 1'b0;
        o_empty_res = 1'b0;
        o_status.marker = r_marker;
        o_status.decimal = (r_kind == urf_pkg::FUNC_DEC);
        o_status.conv_done = (r_iter == 7'd0);
        o_status.norm_done = !((top_digit == 4'd0) && (r_slots != 7'd1));
        o_status.seg_empty = 1'b1;
        case (i_cmd.emit_seg)
            urf_pkg::SEG_LEAD: begin
                o_out_char = r_lead_zero ? urf_pkg::CHAR_ZERO : urf_pkg::CHAR_SPACE;
                o_status.seg_empty = (r_lead_cnt == 7'd0);
            end
            urf_pkg::SEG_PFX: begin
                if (r_pfx_cnt == 2'd1 && r_pfx_hex) begin
                    o_out_char = r_upper ? urf_pkg::CHAR_X_UPPER : urf_pkg::CHAR_X_LOWER;
                end else begin
                    o_out_char = urf_pkg::CHAR_ZERO;
                end
                o_status.seg_empty = (r_pfx_cnt == 2'd0);
            end
            urf_pkg::SEG_ZERO: begin
                o_out_char = urf_pkg::CHAR_ZERO;
                o_status.seg_empty = (r_zero_cnt == 7'd0);
            end
            urf_pkg::SEG_DIGS: begin
                o_out_char = urf_pkg::f_digit_char(top_digit, r_upper);
                o_last = (r_slots == 7'd1) && (r_trail_cnt == 7'd0);
                o_status.seg_empty = (r_slots == 7'd0);
            end
            urf_pkg::SEG_TRAIL: begin
                o_out_char = urf_pkg::CHAR_SPACE;
                o_last = (r_trail_cnt == 7'd1);
                o_status.seg_empty = (r_trail_cnt == 7'd0);
            end
            urf_pkg::SEG_MARK: begin
                o_last = 1'b1;
                o_empty_res = 1'b1;
                o_status.seg_empty = 1'b0;
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/urf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urf_ctrl: sequencer of the unsigned radix formatter
// Steps one word through load, conversion, normalization, sizing and the
// five output segments, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module urf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ready,
    input  urf_pkg::t_status    i_status,
    output urf_pkg::t_cmd       o_cmd,
    output logic                o_in_ready,
    output logic                o_out_valid
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_CONV  = 4'd2;
    localparam logic [3:0] S_NORM  = 4'd3;
    localparam logic [3:0] S_SETUP = 4'd4;
    localparam logic [3:0] S_LEAD  = 4'd5;
    localparam logic [3:0] S_PFX   = 4'd6;
    localparam logic [3:0] S_ZERO  = 4'd7;
    localparam logic [3:0] S_DIGS  = 4'd8;
    localparam logic [3:0] S_TRAIL = 4'd9;
    localparam logic [3:0] S_MARK  = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.emit_seg = urf_pkg::SEG_NONE;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_START;
                end
            end
            S_START: begin
                if (i_status.marker) begin
                    n_state = S_MARK;
                end else if (i_status.decimal) begin
                    n_state = S_CONV;
                end else begin
                    n_state = S_NORM;
                end
            end
            S_CONV: begin
                if (i_status.conv_done) begin
                    n_state = S_NORM;
                end else begin
                    o_cmd.conv_step = 1'b1;
                end
            end
            S_NORM: begin
                if (i_status.norm_done) begin
                    n_state = S_SETUP;
                end else begin
                    o_cmd.norm_step = 1'b1;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state = S_LEAD;
            end
            S_LEAD: begin
                o_cmd.emit_seg = urf_pkg::SEG_LEAD;
                if (i_status.seg_empty) begin
                    n_state = S_PFX;
                end else begin
                    o_out_valid = 1'b1;
                    o_cmd.pop = i_out_ready;
                end
            end
            S_PFX: begin
                o_cmd.emit_seg = urf_pkg::SEG_PFX;
                if (i_status.seg_empty) begin
                    n_state = S_ZERO;
                end else begin
                    o_out_valid = 1'b1;
                    o_cmd.pop = i_out_ready;
                end
            end
            S_ZERO: begin
                o_cmd.emit_seg = urf_pkg::SEG_ZERO;
                if (i_status.seg_empty) begin
                    n_state = S_DIGS;
                end else begin
                    o_out_valid = 1'b1;
                    o_cmd.pop = i_out_ready;
                end
            end
            S_DIGS: begin
                o_cmd.emit_seg = urf_pkg::SEG_DIGS;
                if (i_status.seg_empty) begin
                    n_state = S_TRAIL;
                end else begin
                    o_out_valid = 1'b1;
                    o_cmd.pop = i_out_ready;
                end
            end
            S_TRAIL: begin
                o_cmd.emit_seg = urf_pkg::SEG_TRAIL;
                if (i_status.seg_empty) begin
                    n_state = S_IDLE;
                end else begin
                    o_out_valid = 1'b1;
                    o_cmd.pop = i_out_ready;
                end
            end
            S_MARK: begin
                o_cmd.emit_seg = urf_pkg::SEG_MARK;
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.pop = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/unsigned_radix_formatter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsigned_radix_formatter_top: printf-style unsigned integer formatter
// Converts one value with its conversion spec into ASCII text, one character
// per output word: leading pad, prefix, precision zeros, digits, trailing pad.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Interface   Word
// i_in      in   urf_in_if   value, func, size_mode, flags, precision, width
// o_out     out  urf_out_if  out_char, last, empty_res
//
// Per word: load and decode; for decimal, one double-dabble step per truncated
// value bit (8, 16, 32 or 64); one step per leading zero digit stripped (64,
// 22, 16 or 20 slots for binary, octal, hex, decimal); sizing of segments;
// then the characters of each of the five segments. A zero value with zero
// precision emits only the empty-result marker.
// Reset is synchronous, active low, and returns the sequencer to idle.
// A stalled output holds its word; input is taken only while idle.
// ----------------------------------------------------------------------------
module unsigned_radix_formatter_top #(
    parameter int MAX_FIELD_WIDTH = 64,
    parameter int MAX_PRECISION = 60
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    urf_in_if.sink      i_in,
    urf_out_if.source   o_out
);

    urf_pkg::t_cmd      cmd;
    urf_pkg::t_status   status;

    // Sequencer: owns both handshakes and issues one command set per cycle
    urf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid)
    );

    // Datapath: spec registers, digit conversion, segment counters and the
    // character of the word on offer
    urf_datapath #(
        .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH),
        .MAX_PRECISION   (MAX_PRECISION)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_value       (i_in.value),
        .i_func        (i_in.func),
        .i_size_mode   (i_in.size_mode),
        .i_alternate   (i_in.alternate),
        .i_zero_pad    (i_in.zero_pad),
        .i_left_adjust (i_in.left_adjust),
        .i_precision   (i_in.precision),
        .i_min_width   (i_in.min_width),
        .o_out_char    (o_out.out_char),
        .o_last        (o_out.last),
        .o_empty_res   (o_out.empty_res)
    );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the unsigned radix formatter
// Drives conversion words (value plus spec) into the formatter and checks
// every emitted character against a local predictor of the printf-style
// text. A directed set of edge cases is followed by random words under four
// mixes of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb;

    localparam int WIDTH_CAP = 64;
    localparam int PRECISION_CAP = 60;
    localparam int MAX_CHARS = 64;
    localparam int WORDS_PER_PHASE = 39;
    localparam int TAIL_CYCLES = 200;
    // The slowest words under 79% receiver stalls set the pace; the limit takes
    // the whole run several times over.
    localparam int CYCLE_LIMIT = 1000000;

    // One conversion word as it crosses the input channel
    typedef struct {
        logic [63:0]       value;
        logic [2:0]        func;
        logic [1:0]        size_mode;
        logic              alternate;
        logic              zero_pad;
        logic              left_adjust;
        logic signed [6:0] precision;
        logic [6:0]        min_width;
    } t_conv_word;

    // One expected output character
    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       empty;
    } t_text_char;

    // ------------------------------------------------------------------------
    // Predictor of the formatted text and store of the characters still due.
    // ------------------------------------------------------------------------
    class t_char_scoreboard;
        t_text_char expected_text[$];
        int         errors;
        int         conversions;
        int         markers;
        int         chars_checked;

        function new();
            errors = 0;
            conversions = 0;
            markers = 0;
            chars_checked = 0;
        endfunction

        // Work out the full text of one accepted word and queue it.
        function void note_conversion(t_conv_word w);
            logic [63:0] v;
            logic [63:0] t;
            logic [63:0] radix;
            logic [7:0]  digs[64];
            logic [7:0]  line[$];
            logic [7:0]  fill;
            string       numerals;
            int          prec;
            int          width;
            int          nd;
            int          extra;
            int          pfx;
            int          pad;
            int          i;
            bit          octal;
            bit          hex;
            t_text_char  tc;

            conversions++;
            v = w.value;
            case (w.size_mode)
                urf_pkg::SIZE_8:  v = v & 64'h0000_0000_0000_00FF;
                urf_pkg::SIZE_16: v = v & 64'h0000_0000_0000_FFFF;
                urf_pkg::SIZE_32: v = v & 64'h0000_0000_FFFF_FFFF;
                default: ;
            endcase

            // Any negative precision means none; large ones saturate.
            prec = w.precision[6] ? -1 : int'(w.precision[5:0]);
            if (prec > PRECISION_CAP) prec = PRECISION_CAP;
            width = (w.min_width > WIDTH_CAP) ? WIDTH_CAP : int'(w.min_width);

            octal = 1'b0;
            hex = 1'b0;
            numerals = "0123456789abcdef";
            case (w.func)
                urf_pkg::FUNC_BIN:  radix = 64'd2;
                urf_pkg::FUNC_OCT:  begin radix = 64'd8; octal = 1'b1; end
                urf_pkg::FUNC_HEXL: begin radix = 64'd16; hex = 1'b1; end
                urf_pkg::FUNC_HEXU: begin
                    radix = 64'd16;
                    hex = 1'b1;
                    numerals = "0123456789ABCDEF";
                end
                default:   radix = 64'd10;
            endcase

            // Zero with zero precision prints nothing: a lone marker.
            if (prec == 0 && v == 64'd0) begin
                tc.ch = urf_pkg::CHAR_NUL;
                tc.last = 1'b1;
                tc.empty = 1'b1;
                expected_text.push_back(tc);
                markers++;
                return;
            end

            // Digits come out least significant first.
            t = v;
            nd = 0;
            do begin
                digs[nd] = numerals[int'(t % radix)];
                t = t / radix;
                nd++;
            end while (t != 64'd0 && nd < MAX_CHARS);

            extra = prec - nd;
            pfx = 0;
            if (v != 64'd0 && w.alternate) begin
                if (octal && extra <= 0) pfx = 1;
                else if (hex) pfx = 2;
            end
            pad = width - pfx - ((nd > prec) ? nd : prec);

            fill = (prec < 0 && w.zero_pad) ? urf_pkg::CHAR_ZERO : urf_pkg::CHAR_SPACE;
            if (!w.left_adjust) begin
                for (i = 0; i < pad; i++) line.push_back(fill);
            end
            if (pfx >= 1) line.push_back(urf_pkg::CHAR_ZERO);
            if (pfx == 2) begin
                line.push_back((w.func == urf_pkg::FUNC_HEXU) ? urf_pkg::CHAR_X_UPPER
                                                              : urf_pkg::CHAR_X_LOWER);
            end
            for (i = 0; i < extra; i++) line.push_back(urf_pkg::CHAR_ZERO);
            for (i = nd - 1; i >= 0; i--) line.push_back(digs[i]);
            if (w.left_adjust) begin
                for (i = 0; i < pad; i++) line.push_back(urf_pkg::CHAR_SPACE);
            end

            for (i = 0; i < line.size() && i < MAX_CHARS; i++) begin
                tc.ch = line[i];
                tc.empty = 1'b0;
                tc.last = (i == line.size() - 1) || (i == MAX_CHARS - 1);
                expected_text.push_back(tc);
            end
        endfunction

        // Compare one accepted output word with the oldest expected character.
        function void check_char(logic [7:0] ch, logic last, logic empty);
            t_text_char tc;
            if (expected_text.size() == 0) begin
                $error("unexpected output word: out_char=%02h last=%0b empty_res=%0b",
                       ch, last, empty);
                errors++;
                return;
            end
            tc = expected_text.pop_front();
            chars_checked++;
            if (empty !== tc.empty) begin
                $error("empty_res mismatch: expected %0b, actual %0b", tc.empty, empty);
                errors++;
            end
            if (last !== tc.last) begin
                $error("last mismatch: expected %0b, actual %0b", tc.last, last);
                errors++;
            end
            // out_char carries nothing on the empty marker
            if (!tc.empty && ch !== tc.ch) begin
                $error("out_char mismatch: expected %02h, actual %02h", tc.ch, ch);
                errors++;
            end
        endfunction

        function int pending_count();
            return expected_text.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    urf_in_if  in_ch ();
    urf_out_if out_ch ();

    unsigned_radix_formatter_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_char_scoreboard tracker = new();

    // Percent chance per cycle that the sender idles or the receiver stalls
    int in_idle_pct = 0;
    int out_stall_pct = 0;
    int cycle_count = 0;

    // ------------------------------------------------------------------------
    // Clock: 20 ns period
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if the formatter stops making progress.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d characters still due",
                     cycle_count, tracker.pending_count());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: check every accepted word at the edge, then pick ready for
    // the next cycle. Hold ready low through reset.
    // ------------------------------------------------------------------------
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                tracker.check_char(out_ch.out_char, out_ch.last, out_ch.empty_res);
            end
            out_ch.ready <= i_rst_n && ($urandom_range(99) >= out_stall_pct);
        end
    end

    // Build a conversion word from its fields; precision may be negative.
    function automatic t_conv_word mk(logic [63:0] value, logic [2:0] func,
                                      logic [1:0] size_mode, bit alt, bit zpad,
                                      bit left, int prec, int fw);
        t_conv_word w;
        w.value = value;
        w.func = func;
        w.size_mode = size_mode;
        w.alternate = alt;
        w.zero_pad = zpad;
        w.left_adjust = left;
        w.precision = 7'(prec);
        w.min_width = 7'(fw);
        return w;
    endfunction

    // Random word: mostly legal specs with moderate widths, a few with any
    // bit pattern in precision and width so that every field bit toggles.
    function automatic t_conv_word random_conv();
        t_conv_word w;
        int pick;
        w.value = {$urandom, $urandom};
        pick = $urandom_range(9);
        if (pick < 2) w.value = 64'($urandom_range(20));
        else if (pick == 2) w.value = 64'd0;
        else if (pick == 3) w.value = 64'($urandom);
        w.func = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
        w.size_mode = 2'($urandom_range(3));
        w.alternate = 1'($urandom_range(1));
        w.zero_pad = 1'($urandom_range(1));
        w.left_adjust = 1'($urandom_range(1));
        pick = $urandom_range(9);
        if (pick < 4) w.precision = -7'sd1;
        else if (pick < 8) w.precision = 7'($urandom_range(24));
        else w.precision = 7'($urandom_range(127));
        pick = $urandom_range(9);
        if (pick < 8) w.min_width = 7'($urandom_range(24));
        else w.min_width = 7'($urandom_range(127));
        return w;
    endfunction

    // Offer one word; idle first at random, then hold valid until it moves.
    task automatic send_conv(input t_conv_word w);
        int gap;
        gap = 0;
        while ($urandom_range(99) < in_idle_pct) gap++;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.value <= w.value;
        in_ch.func <= w.func;
        in_ch.size_mode <= w.size_mode;
        in_ch.alternate <= w.alternate;
        in_ch.zero_pad <= w.zero_pad;
        in_ch.left_adjust <= w.left_adjust;
        in_ch.precision <= w.precision;
        in_ch.min_width <= w.min_width;
        in_ch.valid <= 1'b1;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        tracker.note_conversion(w);
    endtask

    // Drop valid and hold off until every queued character has come out.
    task automatic drain_text();
        in_ch.valid <= 1'b0;
        while (tracker.pending_count() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int phase;
        int n;

        in_ch.valid <= 1'b0;
        in_ch.value <= 64'd0;
        in_ch.func <= urf_pkg::FUNC_DEC;
        in_ch.size_mode <= urf_pkg::SIZE_64;
        in_ch.alternate <= 1'b0;
        in_ch.zero_pad <= 1'b0;
        in_ch.left_adjust <= 1'b0;
        in_ch.precision <= -7'sd1;
        in_ch.min_width <= 7'd0;
        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed edge cases, back to back with no idling.
        // Zero with zero precision: marker only, even with width and flags.
        send_conv(mk(64'd0, urf_pkg::FUNC_DEC, urf_pkg::SIZE_64, 0, 0, 0, 0, 0));
        send_conv(mk(64'd0, urf_pkg::FUNC_HEXL, urf_pkg::SIZE_64, 1, 1, 0, 0, 12));
        send_conv(mk(64'd0, urf_pkg::FUNC_DEC, urf_pkg::SIZE_64, 0, 0, 1, 0, 10));
        // Zero value drops the prefix.
        send_conv(mk(64'd0, urf_pkg::FUNC_HEXU, urf_pkg::SIZE_64, 1, 0, 0, -1, 4));
        send_conv(mk(64'd0, urf_pkg::FUNC_OCT, urf_pkg::SIZE_8, 1, 0, 0, -1, 0));
        send_conv(mk(64'd0, urf_pkg::FUNC_BIN, urf_pkg::SIZE_16, 0, 1, 0, 3, 0));
        // Octal prefix dropped under precision zeros, kept otherwise.
        send_conv(mk(64'd8, urf_pkg::FUNC_OCT, urf_pkg::SIZE_8, 1, 0, 0, 5, 0));
        send_conv(mk(64'd8, urf_pkg::FUNC_OCT, urf_pkg::SIZE_8, 1, 0, 0, -1, 6));
        send_conv(mk(64'd7, urf_pkg::FUNC_OCT, urf_pkg::SIZE_32, 1, 0, 0, 1, 0));
        // Zero pad with left adjust pads with trailing spaces.
        send_conv(mk(64'd255, urf_pkg::FUNC_HEXL, urf_pkg::SIZE_8, 1, 1, 1, -1, 8));
        send_conv(mk(64'd255, urf_pkg::FUNC_HEXU, urf_pkg::SIZE_8, 1, 1, 0, -1, 8));
        // All ones through every truncation and every radix.
        send_conv(mk('1, urf_pkg::FUNC_BIN, urf_pkg::SIZE_64, 0, 0, 0, -1, 64));
        send_conv(mk('1, urf_pkg::FUNC_DEC, urf_pkg::SIZE_64, 0, 1, 0, -1, 25));
        send_conv(mk('1, urf_pkg::FUNC_OCT, urf_pkg::SIZE_32, 1, 0, 0, -1, 0));
        send_conv(mk('1, urf_pkg::FUNC_DEC, urf_pkg::SIZE_16, 0, 0, 1, -1, 9));
        send_conv(mk('1, urf_pkg::FUNC_HEXL, urf_pkg::SIZE_8, 1, 0, 0, -1, 0));
        // Unknown conversion codes fall back to decimal.
        send_conv(mk(64'd123, 3'd5, urf_pkg::SIZE_64, 1, 0, 0, -1, 5));
        send_conv(mk(64'd123, 3'd6, urf_pkg::SIZE_64, 0, 1, 0, -1, 5));
        send_conv(mk(64'd123, 3'd7, urf_pkg::SIZE_64, 0, 0, 1, 4, 7));
        // Negative precision other than minus one acts as none.
        send_conv(mk(64'd42, urf_pkg::FUNC_DEC, urf_pkg::SIZE_64, 0, 1, 0, -2, 6));
        send_conv(mk(64'd42, urf_pkg::FUNC_DEC, urf_pkg::SIZE_64, 0, 1, 0, -64, 6));
        // Precision and width beyond their caps saturate.
        send_conv(mk(64'd1, urf_pkg::FUNC_HEXL, urf_pkg::SIZE_64, 1, 0, 0, 63, 0));
        send_conv(mk(64'd1, urf_pkg::FUNC_DEC, urf_pkg::SIZE_64, 0, 0, 0, 61, 127));
        send_conv(mk(64'd5, urf_pkg::FUNC_BIN, urf_pkg::SIZE_64, 0, 0, 1, -1, 65));
        send_conv(mk(64'h8000_0000_0000_0000, urf_pkg::FUNC_HEXU, urf_pkg::SIZE_64,
                     1, 0, 0, 20, 30));
        // Pause until every character is out before the random phases.
        drain_text();

        // Random words under each idle/stall mix; drain between mixes.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 79; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 79; end
                default: begin in_idle_pct = 27; out_stall_pct = 27; end
            endcase
            for (n = 0; n < WORDS_PER_PHASE; n++) send_conv(random_conv());
            drain_text();
        end

        // Let any stray words show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Formatted %0d words (%0d empty markers) into %0d checked characters,",
                 tracker.conversions, tracker.markers, tracker.chars_checked);
        $display("over all radixes, truncations and flags, under four idle/stall mixes.");
        if (tracker.errors == 0 && tracker.pending_count() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/urf_pkg.sv
rtl/urf_if.sv
rtl/urf_datapath.sv
rtl/urf_ctrl.sv
rtl/unsigned_radix_formatter_top.sv
dv/tb.sv
